// ===== design/rrd_pkg.sv =====
`default_nettype none
package rrd_pkg;

	// Default size of the seed row store in bytes.
	localparam int ROW_BYTES_DEF = 4096;
	// Pointer width carried in queue entries, enough for the largest store of 65536 bytes.
	localparam int PTR_W = 17;
	// Depth of the command queue between the front and back parts.
	localparam int FIFO_DEPTH = 4;
	// Width of the output data beat.
	localparam int OUT_DATA_W = 48;
	// Byte address bit that selects the register.
	localparam logic REG_METHOD = 1'b0;

	typedef enum logic [1:0] {
		MODE_DATA  = 2'd0,
		MODE_EMPTY = 2'd1,
		MODE_CLEAR = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		METH_RAW      = 2'd0,
		METH_PAIRS    = 2'd1,
		METH_PACKBITS = 2'd2,
		METH_DELTA    = 2'd3
	} method_t;

	typedef enum logic [2:0] {
		PH_CTRL    = 3'd0,
		PH_PAIRVAL = 3'd1,
		PH_REPVAL  = 3'd2,
		PH_LIT     = 3'd3,
		PH_EXT     = 3'd4,
		PH_DELTA   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		CMD_RUN   = 2'd0,
		CMD_EMPTY = 2'd1,
		CMD_CLEAR = 2'd2
	} cmd_kind_t;

	typedef enum logic [2:0] {
		BK_INIT     = 3'd0,
		BK_IDLE     = 3'd1,
		BK_FILL     = 3'd2,
		BK_CLRSTALE = 3'd3,
		BK_SCANRD   = 3'd4,
		BK_SCANCHK  = 3'd5,
		BK_SEEDCLR  = 3'd6,
		BK_EMIT     = 3'd7
	} back_state_t;

	// One command handed from the front part to the back part.
	typedef struct packed {
		cmd_kind_t          kind;
		logic               wv;
		logic               last;
		logic               ovf;
		logic [PTR_W-1:0]   col;
		logic [8:0]         cnt;
		logic [7:0]         value;
		logic [PTR_W-1:0]   cp_end;
	} cmd_t;

endpackage
`default_nettype wire

// ===== design/raster_row_decompressor.sv =====
`default_nettype none
// Channel      Direction  Beat contents
// s_*          in         tdata: data_byte[7:0]; tuser: mode[1:0]; tlast: row_end
// m_*          out        tdata: see port; tuser: write_valid; tlast: row_done
// APB          in         register 0 at address 0: compression_method[1:0]
//
// The front part takes one beat a cycle once the store is cleared, while the queue has room.
// The back part pops a command, writes each stored byte of a run and then loads the output
// beat; a row end also clears stale bytes, then reads and checks each byte of the trailing
// zero scan before closing it; a seed clear writes each byte up to the highest column
// written. The store's single write port sets this.
// After reset the store is cleared byte by byte before any beat is taken.
// A held output beat stalls the back part only; the front keeps filling the queue.
module raster_row_decompressor #(
	parameter int ROW_BYTES = rrd_pkg::ROW_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [7:0]    s_tdata,   // data_byte[7:0]
	input  wire logic [1:0]    s_tuser,   // mode[1:0]
	input  wire logic          s_tlast,
	output logic               m_tvalid,
	input  wire logic          m_tready,
	// write_column[11:0], write_count[20:12], write_value[28:21], row_length[41:29],
	// line_skip[42], overflow[43], zero[47:44]
	output logic [rrd_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic               m_tuser,   // write_valid
	output logic               m_tlast,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	logic               cfg_we;
	logic [1:0]         method;
	logic               init_busy;
	logic               q_push;
	logic               q_pop;
	logic               q_empty;
	logic               q_full;
	rrd_pkg::cmd_t      q_cmd;
	rrd_pkg::cmd_t      q_head;

	// Register port.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && (paddr[2] == rrd_pkg::REG_METHOD);
	assign prdata = (paddr[2] == rrd_pkg::REG_METHOD) ? {30'd0, method} : '0;

	rrd_front #(
		.ROW_BYTES (ROW_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_mode  (s_tuser),
		.in_byte  (s_tdata),
		.in_last  (s_tlast),
		.cfg_we   (cfg_we),
		.cfg_data (pwdata[1:0]),
		.method   (method),
		.hold     (init_busy),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd)
	);

	rrd_fifo #(
		.DEPTH (rrd_pkg::FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_cmd (q_cmd),
		.pop      (q_pop),
		.head     (q_head),
		.empty    (q_empty),
		.full     (q_full)
	);

	rrd_back #(
		.ROW_BYTES (ROW_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.method    (method),
		.head      (q_head),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.init_busy (init_busy),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata),
		.out_last  (m_tlast),
		.out_user  (m_tuser)
	);
endmodule
`default_nettype wire

// ===== design/rrd_fifo.sv =====
`default_nettype none
module rrd_fifo #(
	parameter int DEPTH = rrd_pkg::FIFO_DEPTH
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire rrd_pkg::cmd_t push_cmd,
	input  wire logic          pop,
	output rrd_pkg::cmd_t      head,
	output logic               empty,
	output logic               full
);
	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	rrd_pkg::cmd_t      mem_q [DEPTH];
	logic [IW-1:0]      wr_q;
	logic [IW-1:0]      rd_q;
	logic [IW:0]        fill_q;

	assign empty = (fill_q == '0);
	assign full  = (fill_q == (IW+1)'(DEPTH));
	assign head  = mem_q[rd_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q   <= '0;
			rd_q   <= '0;
			fill_q <= '0;
		end else begin
			if (push && !full) begin
				wr_q <= (wr_q == IW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop && !empty) begin
				rd_q <= (rd_q == IW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			fill_q <= fill_q + (IW+1)'(push && !full) - (IW+1)'(pop && !empty);
		end
	end
endmodule
`default_nettype wire

// ===== design/rrd_front.sv =====
`default_nettype none
module rrd_front #(
	parameter int ROW_BYTES = rrd_pkg::ROW_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire logic [1:0]    in_mode,
	input  wire logic [7:0]    in_byte,
	input  wire logic          in_last,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_data,
	output logic [1:0]         method,
	input  wire logic          hold,
	input  wire logic          q_full,
	output logic               q_push,
	output rrd_pkg::cmd_t      q_cmd
);
	localparam int PW = $clog2(ROW_BYTES + 1);
	localparam int WW = PW + 10;

	logic [PW-1:0]      cp_q;
	rrd_pkg::phase_t    phase_q;
	logic [8:0]         rr_q;
	logic [7:0]         held_q;
	logic               ovf_q;
	rrd_pkg::method_t   method_q;

	rrd_pkg::phase_t    ph_d;
	logic [8:0]         rr_d;
	logic [7:0]         held_d;
	logic               wr;
	logic [8:0]         cnt;
	logic [7:0]         adv;
	logic [WW-1:0]      sum1;
	logic [PW-1:0]      cp_mid;
	logic [PW-1:0]      room;
	logic [8:0]         kept;
	logic [WW-1:0]      sum2;
	logic [PW-1:0]      cp_new;
	logic               wv;
	logic               ovf_d;
	logic               accept;

	assign method   = method_q;
	assign in_ready = !q_full && !hold;
	assign accept   = in_valid && in_ready;

	// Command decoding of one data byte under the selected method.
	always_comb begin
		ph_d   = phase_q;
		rr_d   = rr_q;
		held_d = held_q;
		wr     = 1'b0;
		cnt    = '0;
		adv    = '0;
		case (method_q)
			rrd_pkg::METH_RAW: begin
				wr  = 1'b1;
				cnt = 9'd1;
			end
			rrd_pkg::METH_PAIRS: begin
				if (phase_q == rrd_pkg::PH_PAIRVAL) begin
					wr   = 1'b1;
					cnt  = {1'b0, held_q} + 9'd1;
					ph_d = rrd_pkg::PH_CTRL;
				end else begin
					held_d = in_byte;
					ph_d   = rrd_pkg::PH_PAIRVAL;
				end
			end
			rrd_pkg::METH_PACKBITS: begin
				if (phase_q == rrd_pkg::PH_REPVAL) begin
					wr   = 1'b1;
					cnt  = rr_q;
					rr_d = '0;
					ph_d = rrd_pkg::PH_CTRL;
				end else if (phase_q == rrd_pkg::PH_LIT) begin
					wr   = 1'b1;
					cnt  = 9'd1;
					rr_d = rr_q - 9'd1;
					if (rr_d == '0) begin
						ph_d = rrd_pkg::PH_CTRL;
					end
				end else if (in_byte > 8'd128) begin
					rr_d = 9'd257 - {1'b0, in_byte};
					ph_d = rrd_pkg::PH_REPVAL;
				end else if (in_byte < 8'd128) begin
					rr_d = {1'b0, in_byte} + 9'd1;
					ph_d = rrd_pkg::PH_LIT;
				end
			end
			default: begin
				if (phase_q == rrd_pkg::PH_EXT) begin
					adv = in_byte;
					if (in_byte != 8'd255) begin
						ph_d = rrd_pkg::PH_DELTA;
					end
				end else if (phase_q == rrd_pkg::PH_DELTA) begin
					wr   = 1'b1;
					cnt  = 9'd1;
					rr_d = rr_q - 9'd1;
					if (rr_d == '0) begin
						ph_d = rrd_pkg::PH_CTRL;
					end
				end else begin
					adv  = {3'b000, in_byte[4:0]};
					rr_d = {6'd0, in_byte[7:5]} + 9'd1;
					ph_d = (in_byte[4:0] == 5'd31) ? rrd_pkg::PH_EXT : rrd_pkg::PH_DELTA;
				end
			end
		endcase
	end

	// Pointer advance, clipping at the end of the store, and the advance past the run.
	always_comb begin
		sum1   = WW'(cp_q) + WW'(adv);
		cp_mid = (sum1 > WW'(ROW_BYTES)) ? PW'(ROW_BYTES) : sum1[PW-1:0];
		room   = PW'(ROW_BYTES) - cp_mid;
		kept   = (WW'(cnt) < WW'(room)) ? cnt : 9'(room);
		sum2   = WW'(cp_mid) + WW'(cnt);
		cp_new = (sum2 > WW'(ROW_BYTES)) ? PW'(ROW_BYTES) : sum2[PW-1:0];
		wv     = wr && (kept != '0);
		ovf_d  = ovf_q || (wr && (kept != cnt));
	end

	// Command built for the back part.
	always_comb begin
		q_cmd        = '0;
		q_push       = 1'b0;
		q_cmd.kind   = rrd_pkg::CMD_RUN;
		case (rrd_pkg::mode_t'(in_mode))
			rrd_pkg::MODE_DATA: begin
				q_cmd.wv     = wv;
				q_cmd.last   = in_last;
				q_cmd.ovf    = ovf_d;
				q_cmd.col    = wv ? rrd_pkg::PTR_W'(cp_mid) : '0;
				q_cmd.cnt    = wv ? kept : '0;
				q_cmd.value  = wv ? in_byte : '0;
				q_cmd.cp_end = rrd_pkg::PTR_W'(cp_new);
				q_push       = accept && (wv || in_last);
			end
			rrd_pkg::MODE_EMPTY: begin
				q_cmd.kind = rrd_pkg::CMD_EMPTY;
				q_push     = accept;
			end
			rrd_pkg::MODE_CLEAR: begin
				q_cmd.kind = rrd_pkg::CMD_CLEAR;
				q_push     = accept;
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	// Decoder state; a row end or an empty or clear beat abandons the partial row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_q     <= '0;
			phase_q  <= rrd_pkg::PH_CTRL;
			rr_q     <= '0;
			held_q   <= '0;
			ovf_q    <= 1'b0;
			method_q <= rrd_pkg::METH_RAW;
		end else begin
			if (accept) begin
				case (rrd_pkg::mode_t'(in_mode))
					rrd_pkg::MODE_DATA: begin
						if (in_last) begin
							cp_q    <= '0;
							phase_q <= rrd_pkg::PH_CTRL;
							rr_q    <= '0;
							held_q  <= '0;
							ovf_q   <= 1'b0;
						end else begin
							cp_q    <= cp_new;
							phase_q <= ph_d;
							rr_q    <= rr_d;
							held_q  <= held_d;
							ovf_q   <= ovf_d;
						end
					end
					rrd_pkg::MODE_EMPTY, rrd_pkg::MODE_CLEAR: begin
						cp_q    <= '0;
						phase_q <= rrd_pkg::PH_CTRL;
						rr_q    <= '0;
						held_q  <= '0;
						ovf_q   <= 1'b0;
					end
					default: begin
						cp_q <= cp_q;
					end
				endcase
			end
			if (cfg_we) begin
				method_q <= rrd_pkg::method_t'(cfg_data);
				phase_q  <= rrd_pkg::PH_CTRL;
				rr_q     <= '0;
				held_q   <= '0;
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/rrd_back.sv =====
`default_nettype none
module rrd_back #(
	parameter int ROW_BYTES = rrd_pkg::ROW_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [1:0]    method,
	input  wire rrd_pkg::cmd_t head,
	input  wire logic          q_empty,
	output logic               q_pop,
	output logic               init_busy,
	output logic               out_valid,
	input  wire logic          out_ready,
	output logic [rrd_pkg::OUT_DATA_W-1:0] out_data,
	output logic               out_last,
	output logic               out_user
);
	localparam int PW = $clog2(ROW_BYTES + 1);
	localparam int AW = $clog2(ROW_BYTES);

	logic [7:0]                 mem [ROW_BYTES];
	logic [7:0]                 rd_q;

	rrd_pkg::back_state_t       state_q, state_d;
	rrd_pkg::cmd_t              cmd_q, cmd_d;
	logic [PW-1:0]              addr_q, addr_d;
	logic [PW-1:0]              end_q, end_d;
	logic [PW-1:0]              prev_q, prev_d;
	logic [PW-1:0]              hw_q, hw_d;
	logic [PW-1:0]              len_q, len_d;
	logic                       done_q, done_d;
	logic                       skip_q, skip_d;

	logic                       ov_q;
	logic [rrd_pkg::OUT_DATA_W-1:0] od_q;
	logic                       ol_q;
	logic                       ou_q;
	logic                       load;

	logic                       we;
	logic [AW-1:0]              wa;
	logic [7:0]                 wd;
	logic [AW-1:0]              ra;

	logic [PW-1:0]              fin_src;
	logic [PW-1:0]              fin_n;
	logic [PW-1:0]              run_end;

	assign init_busy = (state_q == rrd_pkg::BK_INIT);
	assign out_valid = ov_q;
	assign out_data  = od_q;
	assign out_last  = ol_q;
	assign out_user  = ou_q;

	// Row length before stripping: the delta method keeps at least the previous length.
	always_comb begin
		fin_src = (state_q == rrd_pkg::BK_IDLE) ? PW'(head.cp_end) : PW'(cmd_q.cp_end);
		if (rrd_pkg::method_t'(method) == rrd_pkg::METH_DELTA && fin_src < prev_q) begin
			fin_n = prev_q;
		end else begin
			fin_n = fin_src;
		end
		run_end = PW'(head.col) + PW'(head.cnt);
	end

	// Next state, store accesses and queue pop.
	always_comb begin
		state_d = state_q;
		cmd_d   = cmd_q;
		addr_d  = addr_q;
		end_d   = end_q;
		prev_d  = prev_q;
		hw_d    = hw_q;
		len_d   = len_q;
		done_d  = done_q;
		skip_d  = skip_q;
		q_pop   = 1'b0;
		we      = 1'b0;
		wa      = addr_q[AW-1:0];
		wd      = '0;
		ra      = AW'(len_q - PW'(1));
		load    = 1'b0;
		case (state_q)
			rrd_pkg::BK_INIT: begin
				we     = 1'b1;
				addr_d = addr_q + PW'(1);
				if (addr_q == PW'(ROW_BYTES - 1)) begin
					addr_d  = '0;
					state_d = rrd_pkg::BK_IDLE;
				end
			end
			rrd_pkg::BK_IDLE: begin
				if (!q_empty) begin
					q_pop  = 1'b1;
					cmd_d  = head;
					done_d = 1'b0;
					skip_d = 1'b0;
					len_d  = '0;
					case (head.kind)
						rrd_pkg::CMD_RUN: begin
							if (head.wv) begin
								addr_d  = PW'(head.col);
								end_d   = run_end;
								hw_d    = (run_end > hw_q) ? run_end : hw_q;
								state_d = rrd_pkg::BK_FILL;
							end else begin
								addr_d  = fin_n;
								len_d   = fin_n;
								done_d  = 1'b1;
								state_d = rrd_pkg::BK_CLRSTALE;
							end
						end
						rrd_pkg::CMD_EMPTY: begin
							if (rrd_pkg::method_t'(method) == rrd_pkg::METH_DELTA
								&& prev_q != '0) begin
								addr_d  = fin_n;
								len_d   = fin_n;
								done_d  = 1'b1;
								state_d = rrd_pkg::BK_CLRSTALE;
							end else begin
								skip_d  = 1'b1;
								addr_d  = '0;
								state_d = rrd_pkg::BK_SEEDCLR;
							end
						end
						default: begin
							addr_d  = '0;
							state_d = rrd_pkg::BK_SEEDCLR;
						end
					endcase
				end
			end
			rrd_pkg::BK_FILL: begin
				we     = 1'b1;
				wd     = cmd_q.value;
				addr_d = addr_q + PW'(1);
				if (addr_q + PW'(1) == end_q) begin
					if (cmd_q.last) begin
						addr_d  = fin_n;
						len_d   = fin_n;
						done_d  = 1'b1;
						state_d = rrd_pkg::BK_CLRSTALE;
					end else begin
						state_d = rrd_pkg::BK_EMIT;
					end
				end
			end
			rrd_pkg::BK_CLRSTALE: begin
				if (addr_q < prev_q) begin
					we     = 1'b1;
					addr_d = addr_q + PW'(1);
				end else begin
					state_d = rrd_pkg::BK_SCANRD;
				end
			end
			rrd_pkg::BK_SCANRD: begin
				if (len_q == '0) begin
					prev_d  = len_q;
					state_d = rrd_pkg::BK_EMIT;
				end else begin
					state_d = rrd_pkg::BK_SCANCHK;
				end
			end
			rrd_pkg::BK_SCANCHK: begin
				if (rd_q == 8'd0) begin
					len_d   = len_q - PW'(1);
					state_d = rrd_pkg::BK_SCANRD;
				end else begin
					prev_d  = len_q;
					state_d = rrd_pkg::BK_EMIT;
				end
			end
			rrd_pkg::BK_SEEDCLR: begin
				if (addr_q < hw_q) begin
					we     = 1'b1;
					addr_d = addr_q + PW'(1);
				end else begin
					hw_d    = '0;
					prev_d  = '0;
					state_d = skip_q ? rrd_pkg::BK_EMIT : rrd_pkg::BK_IDLE;
				end
			end
			default: begin
				if (!ov_q || out_ready) begin
					load    = 1'b1;
					state_d = rrd_pkg::BK_IDLE;
				end
			end
		endcase
	end

	// Seed row store with one write port and a registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_q <= mem[ra];
	end

	// Control state of the back part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrd_pkg::BK_INIT;
			addr_q  <= '0;
			prev_q  <= '0;
			hw_q    <= '0;
			done_q  <= 1'b0;
			skip_q  <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
			prev_q  <= prev_d;
			hw_q    <= hw_d;
			done_q  <= done_d;
			skip_q  <= skip_d;
			if (load) begin
				ov_q <= 1'b1;
			end else if (out_ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Working payload and the output register.
	always_ff @(posedge clk) begin
		cmd_q <= cmd_d;
		end_q <= end_d;
		len_q <= len_d;
		if (load) begin
			od_q <= {4'd0, cmd_q.ovf, skip_q, 13'(done_q ? len_q : '0),
				cmd_q.value, cmd_q.cnt, 12'(cmd_q.col)};
			ol_q <= done_q;
			ou_q <= cmd_q.wv;
		end
	end
endmodule
`default_nettype wire

// ===== tb/raster_row_decompressor_test.sv =====
`default_nettype none
module raster_row_decompressor_test;
	timeunit 1ns;
	timeprecision 1ps;
	import rrd_pkg::*;

	localparam int STORE = ROW_BYTES_DEF;
	// Worst back-end drain: zero scan, stale clear and seed clear over the whole store.
	localparam int DRAIN_CYCLES = 4 * STORE + 64;

	typedef struct {
		logic        wv;
		logic [11:0] col;
		logic [8:0]  cnt;
		logic [7:0]  val;
		logic        done;
		logic [12:0] len;
		logic        skip;
		logic        ovf;
	} row_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;
	logic [1:0]  s_tuser = 2'd0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	raster_row_decompressor u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.s_tuser(s_tuser), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tuser(m_tuser), .m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Decoder copy used to work out the expected row results.
	logic [7:0]  seed_copy [STORE];
	int unsigned prev_len;
	int unsigned col_ptr;
	phase_t      dec_phase;
	int unsigned run_left;
	int unsigned held_count;
	logic        ovf_seen;
	method_t     cur_method;

	row_result_t pending_rows [$];
	int          errors = 0;
	bit          idle_on = 1'b1;
	int          data_beats = 0;

	task automatic report(input string what, input int got, input int want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	function automatic void clear_seed_copy();
		for (int i = 0; i < STORE; i++)
			seed_copy[i] = 8'd0;
		prev_len = 0;
	endfunction

	function automatic void drop_partial_row();
		col_ptr = 0;
		dec_phase = PH_CTRL;
		run_left = 0;
		held_count = 0;
		ovf_seen = 1'b0;
	endfunction

	function automatic void step_pointer(input int unsigned n);
		col_ptr = (col_ptr + n > STORE) ? STORE : col_ptr + n;
	endfunction

	function automatic void select_method(input method_t m);
		cur_method = m;
		dec_phase = PH_CTRL;
		run_left = 0;
		held_count = 0;
	endfunction

	// Clears stale bytes, strips trailing zeros and returns the new length.
	function automatic int unsigned close_row();
		int unsigned n;
		n = col_ptr;
		if (cur_method == METH_DELTA && n < prev_len)
			n = prev_len;
		for (int unsigned i = n; i < prev_len && i < STORE; i++)
			seed_copy[i] = 8'd0;
		while (n > 0 && seed_copy[n-1] == 8'd0)
			n--;
		prev_len = n;
		return n;
	endfunction

	// Expected result of one accepted input beat, if it causes one.
	function automatic void predict_row_beat(input logic [1:0] mode, input logic [7:0] b,
			input logic last);
		row_result_t r;
		int unsigned cnt;
		int unsigned room;
		int unsigned kept;
		bit wr;
		r = '{default: '0};
		cnt = 0;
		wr = 0;
		if (mode == MODE_CLEAR) begin
			clear_seed_copy();
			drop_partial_row();
			return;
		end
		if (mode == MODE_NONE)
			return;
		if (mode == MODE_EMPTY) begin
			drop_partial_row();
			if (cur_method == METH_DELTA && prev_len != 0) begin
				r.done = 1'b1;
				r.len = close_row();
			end else begin
				clear_seed_copy();
				r.skip = 1'b1;
			end
			pending_rows.push_back(r);
			return;
		end
		case (cur_method)
			METH_RAW: begin
				cnt = 1; wr = 1;
			end
			METH_PAIRS: begin
				if (dec_phase == PH_PAIRVAL) begin
					cnt = held_count + 1; wr = 1;
					dec_phase = PH_CTRL;
				end else begin
					held_count = b;
					dec_phase = PH_PAIRVAL;
				end
			end
			METH_PACKBITS: begin
				if (dec_phase == PH_REPVAL) begin
					cnt = run_left; wr = 1;
					run_left = 0;
					dec_phase = PH_CTRL;
				end else if (dec_phase == PH_LIT) begin
					cnt = 1; wr = 1;
					run_left--;
					if (run_left == 0)
						dec_phase = PH_CTRL;
				end else if (b > 8'd128) begin
					run_left = 257 - b;
					dec_phase = PH_REPVAL;
				end else if (b < 8'd128) begin
					run_left = b + 1;
					dec_phase = PH_LIT;
				end
			end
			default: begin
				if (dec_phase == PH_EXT) begin
					step_pointer(b);
					if (b != 8'd255)
						dec_phase = PH_DELTA;
				end else if (dec_phase == PH_DELTA) begin
					cnt = 1; wr = 1;
					run_left--;
					if (run_left == 0)
						dec_phase = PH_CTRL;
				end else begin
					run_left = b[7:5] + 1;
					step_pointer(b[4:0]);
					dec_phase = (b[4:0] == 5'd31) ? PH_EXT : PH_DELTA;
				end
			end
		endcase
		// Store the run, clipped to the room left in the store.
		if (wr) begin
			room = STORE - col_ptr;
			kept = (cnt < room) ? cnt : room;
			if (kept < cnt)
				ovf_seen = 1'b1;
			for (int unsigned i = 0; i < kept; i++)
				seed_copy[col_ptr + i] = b;
			if (kept != 0) begin
				r.wv = 1'b1;
				r.col = col_ptr[11:0];
				r.cnt = kept[8:0];
				r.val = b;
			end
			step_pointer(cnt);
		end
		r.ovf = ovf_seen;
		if (last) begin
			r.done = 1'b1;
			r.len = close_row();
			drop_partial_row();
		end
		if (r.wv || r.done)
			pending_rows.push_back(r);
	endfunction

	// Receiver stalls in bursts.
	int stall_left = 0;
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left <= $urandom_range(0, 5);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Each output beat is compared with the oldest expected row result.
	always @(posedge clk) begin
		row_result_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_rows.size() == 0) begin
				report("unexpected beat", 1, 0);
			end else begin
				e = pending_rows.pop_front();
				if (m_tuser !== e.wv) report("write_valid", m_tuser, e.wv);
				if (m_tdata[11:0] !== e.col) report("write_column", m_tdata[11:0], e.col);
				if (m_tdata[20:12] !== e.cnt) report("write_count", m_tdata[20:12], e.cnt);
				if (m_tdata[28:21] !== e.val) report("write_value", m_tdata[28:21], e.val);
				if (m_tlast !== e.done) report("row_done", m_tlast, e.done);
				if (m_tdata[41:29] !== e.len) report("row_length", m_tdata[41:29], e.len);
				if (m_tdata[42] !== e.skip) report("line_skip", m_tdata[42], e.skip);
				if (m_tdata[43] !== e.ovf) report("overflow", m_tdata[43], e.ovf);
				if (m_tdata[47:44] !== 4'd0) report("pad bits", m_tdata[47:44], 0);
			end
		end
	end

	// Sends one input beat; tvalid stays high for a following beat.
	task automatic send_beat(input logic [1:0] mode, input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= mode;
		s_tdata <= b;
		s_tlast <= last;
		do
			@(posedge clk);
		while (!s_tready);
		if (mode == MODE_DATA)
			data_beats++;
		predict_row_beat(mode, b, last);
	endtask

	task automatic send_row(input logic [7:0] bytes [$]);
		foreach (bytes[i])
			send_beat(MODE_DATA, bytes[i], i == bytes.size() - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write then read back, only with the block drained.
	task automatic set_method(input method_t m);
		wait_drained();
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= {REG_METHOD, 2'b00}; pwdata <= 32'(m);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		select_method(m);
		pwrite <= 1'b0; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[1:0] !== m) report("method readback", prdata[1:0], m);
		psel <= 1'b0; penable <= 1'b0;
	endtask

	task automatic test_raw();
		set_method(METH_RAW);
		send_row('{8'h00, 8'hff, 8'h80, 8'h00});
		send_row('{8'h00, 8'h00});
	endtask

	task automatic test_pairs();
		set_method(METH_PAIRS);
		send_row('{8'h00, 8'h55, 8'hff, 8'haa, 8'h03, 8'h00, 8'h07});
	endtask

	task automatic test_packbits();
		set_method(METH_PACKBITS);
		send_row('{8'h80, 8'h02, 8'h01, 8'h02, 8'h03, 8'h81, 8'h7e, 8'hff, 8'h11,
			8'h05, 8'h21, 8'h22});
	endtask

	// Delta rows, empty row repeat, method change inside a row, skip, clear.
	task automatic test_delta();
		set_method(METH_DELTA);
		send_row('{8'h20, 8'h0a, 8'h0b, 8'h1f, 8'hff, 8'h03, 8'h44});
		send_beat(MODE_EMPTY, 8'h00, 1'b0);
		send_beat(MODE_DATA, 8'h43, 1'b0);
		send_beat(MODE_DATA, 8'h99, 1'b0);
		set_method(METH_RAW);
		send_row('{8'h01, 8'h02});
		send_beat(MODE_EMPTY, 8'hff, 1'b1);
		send_beat(MODE_NONE, 8'h5a, 1'b1);
		send_row('{8'h07});
		send_beat(MODE_CLEAR, 8'ha5, 1'b0);
		send_beat(MODE_EMPTY, 8'h00, 1'b0);
	endtask

	// Offset extensions run the pointer near the end of the store, so the run after them overflows.
	task automatic test_overflow();
		logic [7:0] bytes [$];
		set_method(METH_DELTA);
		bytes.push_back(8'hff);
		repeat (15) bytes.push_back(8'hff);
		bytes.push_back(8'd233);
		repeat (8) bytes.push_back(8'h3c);
		send_row(bytes);
	endtask

	function automatic logic [7:0] rand_value();
		return ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
	endfunction

	// One well-formed row for the method, sometimes cut short or preceded by a non-data beat.
	task automatic random_row();
		logic [7:0] bytes [$];
		int n;
		int k;
		n = $urandom_range(1, 6);
		for (int c = 0; c < n; c++) begin
			case (cur_method)
				METH_RAW: repeat ($urandom_range(1, 8)) bytes.push_back(rand_value());
				METH_PAIRS: begin
					bytes.push_back(($urandom_range(0, 15) == 0) ?
						8'($urandom_range(0, 255)) : 8'($urandom_range(0, 7)));
					bytes.push_back(rand_value());
				end
				METH_PACKBITS: begin
					k = $urandom_range(0, 9);
					if (k == 0) begin
						bytes.push_back(8'h80);
					end else if (k < 5) begin
						k = $urandom_range(0, 6);
						bytes.push_back(8'(k));
						repeat (k + 1) bytes.push_back(rand_value());
					end else begin
						bytes.push_back(8'($urandom_range(129, 255)));
						bytes.push_back(rand_value());
					end
				end
				default: begin
					k = $urandom_range(0, 7);
					if ($urandom_range(0, 7) == 0) begin
						bytes.push_back({3'(k), 5'd31});
						repeat ($urandom_range(0, 1)) bytes.push_back(8'hff);
						bytes.push_back(8'($urandom_range(0, 254)));
					end else begin
						bytes.push_back({3'(k), 5'($urandom_range(0, 30))});
					end
					repeat (k + 1) bytes.push_back(rand_value());
				end
			endcase
		end
		if ($urandom_range(0, 7) == 0 && bytes.size() > 1)
			bytes = bytes[0:$urandom_range(0, bytes.size() - 2)];
		if ($urandom_range(0, 9) == 0)
			send_beat(2'($urandom_range(MODE_EMPTY, MODE_NONE)), 8'($urandom_range(0, 255)),
				1'($urandom_range(0, 1)));
		send_row(bytes);
	endtask

	task automatic test_random(input method_t m, input int beats);
		int stop_at;
		set_method(m);
		stop_at = data_beats + beats;
		while (data_beats < stop_at)
			random_row();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		clear_seed_copy();
		drop_partial_row();
		select_method(METH_RAW);
		test_raw();
		test_pairs();
		test_packbits();
		test_delta();
		test_overflow();
		test_random(METH_DELTA, 150);
		test_random(METH_RAW, 120);
		test_random(METH_PAIRS, 160);
		test_random(METH_PACKBITS, 160);
		test_random(METH_DELTA, 120);
		idle_on = 1'b0;
		test_random(METH_PAIRS, 100);
		wait_drained();
		if (errors == 0)
			$display("raster_row_decompressor_test: done, clean");
		else
			$display("raster_row_decompressor_test: done, errors");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("raster_row_decompressor_test: done, errors");
		$finish;
	end
endmodule
`default_nettype wire

// ===== sim.f =====
design/rrd_pkg.sv
design/rrd_fifo.sv
design/rrd_front.sv
design/rrd_back.sv
design/raster_row_decompressor.sv
tb/raster_row_decompressor_test.sv
